FILE: rtl/pose_relative_to_first_frame_core_assert.svh
// Assertion macros for the relative pose core.
// Used by the top level only; relies on clk and rst_n in the including scope.
`ifndef POSE_RELATIVE_TO_FIRST_FRAME_CORE_ASSERT_SVH
`define POSE_RELATIVE_TO_FIRST_FRAME_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PRTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRTF_ASSERT_NOW(lbl, ante, cons, msg)
`define PRTF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/prtf_pkg.sv
// Shared types and constant tables for the relative pose core.
// No dependencies.
package prtf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_LOAD,
    ST_QMUL,
    ST_RMUL,
    ST_TMUL,
    ST_FIN
  } prtf_state_t;

  // operand pairs for the rotation matrix products: ww xx yy zz xy xz yz wx wy wz
  localparam logic [1:0] RM_A [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] RM_B [10] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3};
  localparam int unsigned RM_LAST = 9;

  // subtract mask for conj(q0)*q, bit index {row, col}
  localparam logic [15:0] QM_NEG = 16'b1010_1100_0110_0000;

endpackage

FILE: rtl/prtf_mul.sv
// Shared signed multiplier with registered product.
// No dependencies.
module prtf_mul #(
  parameter int AW = 34,
  parameter int BW = 33
) (
  input  logic                     clk,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p_r
);
  always_ff @(posedge clk) begin
    p_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end
endmodule

FILE: rtl/prtf_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// No dependencies.
module prtf_sqrt #(
  parameter int SW = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [SW-1:0]             s,
  output logic                      done_r,
  output logic [(SW+1)/2-1:0]       root_r
);
  localparam int RTW = (SW + 1) / 2;
  localparam int SEW = 2 * RTW;
  localparam int CW  = $clog2(RTW + 1);

  logic [SEW-1:0] sh_r;
  logic [RTW:0]   rem_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic [RTW+2:0] remx;
  logic [RTW+2:0] trial;
  logic           ge;

  always_comb begin
    remx  = {rem_r, sh_r[SEW-1:SEW-2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = remx >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sh_r   <= SEW'(s);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        sh_r <= sh_r << 2;
        if (ge) begin
          rem_r  <= (RTW+1)'(remx - trial);
          root_r <= {root_r[RTW-2:0], 1'b1};
        end else begin
          rem_r  <= remx[RTW:0];
          root_r <= {root_r[RTW-2:0], 1'b0};
        end
        if (cnt_r == CW'(RTW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end
endmodule

FILE: rtl/prtf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module prtf_div #(
  parameter int NW  = 31,
  parameter int DNW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NW-1:0]   num,
  input  logic [DNW-1:0]  den,
  output logic            done_r,
  output logic [NW-1:0]   quo_r
);
  localparam int CW = $clog2(NW + 1);

  logic [DNW-1:0] den_r;
  logic [DNW-1:0] rem_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic [DNW:0]   remx;
  logic           ge;

  always_comb begin
    remx = {rem_r, quo_r[NW-1]};
    ge   = remx >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? DNW'(remx - {1'b0, den_r}) : remx[DNW-1:0];
        quo_r <= {quo_r[NW-2:0], ge};
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end
endmodule

FILE: rtl/pose_relative_to_first_frame_core.sv
// Relative pose core: sequencer, shared multiply-accumulate, norm and divide.
// Depends on prtf_pkg, prtf_mul, prtf_sqrt, prtf_div and the assertion header.
//
// Usage: poses enter on the in_ channel (valid/stall); one result per pose
// leaves on the out_ channel. A pose with in_first_of_run set, or the first
// pose after reset, becomes the origin. Each result is conj(q0)*q and the
// translation difference rotated by conj(q0), rounded and saturated;
// out_saturated flags clipping of any translation component.
// Steps per pose: squares, square root, normalizing division of each
// component (skipped for a zero norm), load, rotation product, matrix
// products, translation, finish; the idle step then takes the next pose.
// The one multiplier and the serial divider set the pace; the block takes
// one pose at a time and holds in_stall high while it works and during reset.
// The result sits in an output register; the next pose is accepted while it
// waits, and the finish step holds while out_stall is high and it is unread.
// Reset (synchronous, rst_n low) clears the origin and the handshake state.
module pose_relative_to_first_frame_core #(
  parameter int TRANS_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_first_of_run,
  input  logic signed [TRANS_WIDTH-1:0]  in_tx,
  input  logic signed [TRANS_WIDTH-1:0]  in_ty,
  input  logic signed [TRANS_WIDTH-1:0]  in_tz,
  input  logic signed [QUAT_WIDTH-1:0]   in_qw,
  input  logic signed [QUAT_WIDTH-1:0]   in_qx,
  input  logic signed [QUAT_WIDTH-1:0]   in_qy,
  input  logic signed [QUAT_WIDTH-1:0]   in_qz,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [TRANS_WIDTH-1:0]  out_tx,
  output logic signed [TRANS_WIDTH-1:0]  out_ty,
  output logic signed [TRANS_WIDTH-1:0]  out_tz,
  output logic signed [QUAT_WIDTH-1:0]   out_qw,
  output logic signed [QUAT_WIDTH-1:0]   out_qx,
  output logic signed [QUAT_WIDTH-1:0]   out_qy,
  output logic signed [QUAT_WIDTH-1:0]   out_qz,
  output logic                           out_saturated
);
  import prtf_pkg::*;

  localparam int TW     = TRANS_WIDTH;
  localparam int QW     = QUAT_WIDTH;
  localparam int F      = QW - 2;
  localparam int PRW    = 2 * QW;
  localparam int MA     = 2 * QW + 2;
  localparam int MB     = (TW + 1 > QW) ? TW + 1 : QW;
  localparam int PW     = MA + MB;
  localparam int ACCW   = PW + 2;
  localparam int SW_RAW = 2 * QW + 1;
  localparam int SW     = (SW_RAW > 64) ? 64 : SW_RAW;
  localparam int RTW    = (SW + 1) / 2;
  localparam int DW     = 2 * QW - 1;

  prtf_state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  logic       ph_r;
  logic [1:0] ci, cj;

  logic                   first_r, have_r;
  logic signed [QW-1:0]   qr_r [4];
  logic signed [QW-1:0]   q_r  [4];
  logic signed [QW-1:0]   q0_r [4];
  logic signed [QW-1:0]   qn_r [4];
  logic signed [TW-1:0]   t_r  [3];
  logic signed [TW-1:0]   t0_r [3];
  logic signed [PRW-1:0]  pr_r [10];
  logic signed [ACCW-1:0] acc_r [4];
  logic [RTW-1:0]         nrm_r;
  logic                   out_valid_r;

  logic                   in_fire, out_ready;
  logic                   sq_start, dv_start, sq_done, dv_done;
  logic [SW-1:0]          s_in;
  logic [RTW-1:0]         sq_root;
  logic [DW-1:0]          dv_num, dv_quo;
  logic [QW-1:0]          qmag;
  logic signed [MA-1:0]   mul_a, rsel;
  logic signed [MB-1:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   acc_neg;
  logic [1:0]             acc_sel;
  logic [ACCW+1:0]        fin_t [3];
  logic [ACCW+1:0]        fin_q [4];

  assign ci = cnt_r[3:2];
  assign cj = cnt_r[1:0];
  assign in_fire   = in_valid && !in_stall;
  assign out_ready = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // round half away from zero by sh bits, saturate to ow bits: {clip, value}
  function automatic logic [ACCW+1:0] rnd_sat(logic signed [ACCW-1:0] v, int sh, int ow);
    logic            neg;
    logic [ACCW-1:0] mag;
    logic [ACCW:0]   m, lim, val, res;
    logic            clip;
    neg  = v[ACCW-1];
    mag  = neg ? ACCW'(-v) : ACCW'(v);
    m    = ({1'b0, mag} + ((ACCW+1)'(1) << (sh - 1))) >> sh;
    lim  = ((ACCW+1)'(1) << (ow - 1)) - (ACCW+1)'(!neg);
    clip = m > lim;
    val  = clip ? lim : m;
    res  = neg ? (ACCW+1)'(-val) : val;
    return {clip, res};
  endfunction

  generate
    if (SW_RAW > 64) begin : g_sclamp
      assign s_in = (|acc_r[0][SW_RAW-1:64]) ? '1 : acc_r[0][63:0];
    end else begin : g_snoclamp
      assign s_in = acc_r[0][SW-1:0];
    end
  endgenerate

  assign qmag   = qr_r[cj][QW-1] ? QW'(-qr_r[cj]) : QW'(qr_r[cj]);
  assign dv_num = (DW'(qmag) << F) + DW'(nrm_r >> 1);

  prtf_sqrt #(.SW(SW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .s(s_in),
    .done_r(sq_done), .root_r(sq_root)
  );

  prtf_div #(.NW(DW), .DNW(RTW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(nrm_r),
    .done_r(dv_done), .quo_r(dv_quo)
  );

  prtf_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p)
  );

  // rotation matrix of conj(q0) from the stored products
  always_comb begin
    logic signed [MA-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, a;
    ww = MA'(pr_r[0]);
    xx = MA'(pr_r[1]);
    yy = MA'(pr_r[2]);
    zz = MA'(pr_r[3]);
    xy = MA'(pr_r[4]);
    xz = MA'(pr_r[5]);
    yz = MA'(pr_r[6]);
    wx = MA'(pr_r[7]);
    wy = MA'(pr_r[8]);
    wz = MA'(pr_r[9]);
    a  = ww - xx - yy - zz;
    case ({ci, cj})
      4'h0:    rsel = a + (xx <<< 1);
      4'h1:    rsel = (xy + wz) <<< 1;
      4'h2:    rsel = (xz - wy) <<< 1;
      4'h4:    rsel = (xy - wz) <<< 1;
      4'h5:    rsel = a + (yy <<< 1);
      4'h6:    rsel = (yz + wx) <<< 1;
      4'h8:    rsel = (xz + wy) <<< 1;
      4'h9:    rsel = (yz - wx) <<< 1;
      4'hA:    rsel = a + (zz <<< 1);
      default: rsel = '0;
    endcase
  end

  // multiplier operands and accumulator target
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_neg = 1'b0;
    acc_sel = 2'd0;
    case (state_r)
      ST_SQ: begin
        mul_a = MA'(qr_r[cj]);
        mul_b = MB'(qr_r[cj]);
      end
      ST_QMUL: begin
        mul_a   = MA'(q0_r[cj]);
        mul_b   = MB'(q_r[ci ^ cj]);
        acc_neg = QM_NEG[cnt_r];
        acc_sel = ci;
      end
      ST_RMUL: begin
        mul_a = MA'(q0_r[RM_A[cnt_r]]);
        mul_b = MB'(q0_r[RM_B[cnt_r]]);
      end
      ST_TMUL: begin
        mul_a   = rsel;
        mul_b   = MB'(t_r[cj]) - MB'(t0_r[cj]);
        acc_sel = ci;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) fin_t[i] = rnd_sat(acc_r[i], 2 * F, TW);
    for (int i = 0; i < 4; i++) fin_q[i] = rnd_sat(acc_r[i], F, QW);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_SQ;
      ST_SQ:   if (ph_r && cnt_r == 4'd3) state_nxt = ST_ROOT;
      ST_ROOT: if (ph_r && sq_done) state_nxt = ST_DIV;
      ST_DIV: begin
        if (cj == 2'd3 && ((!ph_r && nrm_r == '0) || (ph_r && dv_done)))
          state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_QMUL;
      ST_QMUL: if (ph_r && cnt_r == 4'd15) state_nxt = ST_RMUL;
      ST_RMUL: if (ph_r && cnt_r == 4'(RM_LAST)) state_nxt = ST_TMUL;
      ST_TMUL: if (ph_r && cnt_r == {2'd2, 2'd2}) state_nxt = ST_FIN;
      ST_FIN:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    sq_start = 1'b0;
    dv_start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = !rst_n;
      ST_ROOT: sq_start = !ph_r;
      ST_DIV:  dv_start = !ph_r && nrm_r != '0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ph_r        <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) q0_r[i] <= '0;
      for (int i = 0; i < 3; i++) t0_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_ready) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          ph_r  <= 1'b0;
          if (in_fire) begin
            first_r  <= in_first_of_run;
            t_r[0]   <= in_tx;
            t_r[1]   <= in_ty;
            t_r[2]   <= in_tz;
            qr_r[0]  <= in_qw;
            qr_r[1]  <= in_qx;
            qr_r[2]  <= in_qy;
            qr_r[3]  <= in_qz;
            acc_r[0] <= '0;
          end
        end
        ST_SQ: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            acc_r[0] <= acc_r[0] + ACCW'(mul_p);
            cnt_r    <= (cnt_r == 4'd3) ? '0 : cnt_r + 1'b1;
          end
        end
        ST_ROOT: begin
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else if (sq_done) begin
            nrm_r <= sq_root;
            ph_r  <= 1'b0;
          end
        end
        ST_DIV: begin
          if (!ph_r) begin
            if (nrm_r == '0) begin
              q_r[cj] <= '0;
              cnt_r   <= (cj == 2'd3) ? '0 : cnt_r + 1'b1;
            end else begin
              ph_r <= 1'b1;
            end
          end else if (dv_done) begin
            q_r[cj] <= qr_r[cj][QW-1] ? -$signed(dv_quo[QW-1:0]) : $signed(dv_quo[QW-1:0]);
            cnt_r   <= (cj == 2'd3) ? '0 : cnt_r + 1'b1;
            ph_r    <= 1'b0;
          end
        end
        ST_LOAD: begin
          cnt_r <= '0;
          ph_r  <= 1'b0;
          for (int i = 0; i < 4; i++) acc_r[i] <= '0;
          if (first_r || !have_r) begin
            for (int i = 0; i < 4; i++) q0_r[i] <= q_r[i];
            for (int i = 0; i < 3; i++) t0_r[i] <= t_r[i];
            have_r <= 1'b1;
          end
        end
        ST_QMUL, ST_TMUL: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            acc_r[acc_sel] <= acc_neg ? acc_r[acc_sel] - ACCW'(mul_p)
                                      : acc_r[acc_sel] + ACCW'(mul_p);
            if (state_nxt != state_r) cnt_r <= '0;
            else if (state_r == ST_TMUL && cj == 2'd2) cnt_r <= {ci + 2'd1, 2'd0};
            else cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_RMUL: begin
          ph_r <= !ph_r;
          if (!ph_r && cnt_r == '0) begin
            for (int i = 0; i < 4; i++) qn_r[i] <= $signed(fin_q[i][QW-1:0]);
          end
          if (ph_r) begin
            pr_r[cnt_r] <= PRW'(mul_p);
            if (cnt_r == 4'(RM_LAST)) begin
              cnt_r <= '0;
              for (int i = 0; i < 4; i++) acc_r[i] <= '0;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_ready) begin
            out_tx        <= $signed(fin_t[0][TW-1:0]);
            out_ty        <= $signed(fin_t[1][TW-1:0]);
            out_tz        <= $signed(fin_t[2][TW-1:0]);
            out_qw        <= qn_r[0];
            out_qx        <= qn_r[1];
            out_qy        <= qn_r[2];
            out_qz        <= qn_r[3];
            out_saturated <= fin_t[0][ACCW+1] | fin_t[1][ACCW+1] | fin_t[2][ACCW+1];
          end
        end
        default: begin
          ph_r <= 1'b0;
        end
      endcase
    end
  end

`include "pose_relative_to_first_frame_core_assert.svh"

  `PRTF_ASSERT_NEXT(a_accept_starts, in_fire, state_r == ST_SQ, "accepted item did not start")
  `PRTF_ASSERT_NOW(a_origin_loaded, state_r == ST_QMUL, have_r, "no origin at rotation product")
  `PRTF_ASSERT_NEXT(a_fin_delivers, state_r == ST_FIN && out_ready, out_valid_r, "result lost")

endmodule
